// File: src/double_to_rational_assert.svh
// ----------------------------------------------------------------------------
// double_to_rational assertion macros
// Shared property wrappers for the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_TO_RATIONAL_ASSERT_SVH
`define DOUBLE_TO_RATIONAL_ASSERT_SVH

// Clocked property that is switched off while reset is held.
`define D2R_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define D2R_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/d2r_pkg.sv
// ----------------------------------------------------------------------------
// d2r_pkg
// Field widths, bit positions and IEEE-754 double constants for the
// double to rational converter.
// ----------------------------------------------------------------------------
`default_nettype none

package d2r_pkg;

    localparam int FRAC_BITS   = 52;
    localparam int EXP_BITS    = 11;
    localparam int WORD_BITS   = 64;

    localparam logic [EXP_BITS-1:0] EXP_MAX = 11'h7FF;
    localparam logic signed [12:0]  EXP_BIAS = 13'sd1023;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 136;

    localparam int NEG_BIT     = 0;
    localparam int NUM_LSB     = 1;
    localparam int NUM_MSB     = 64;
    localparam int DEN_LSB     = 65;
    localparam int DEN_MSB     = 128;

    typedef logic [IN_TDATA_W-1:0]  in_tdata_t;
    typedef logic [OUT_TDATA_W-1:0] out_tdata_t;

endpackage

`default_nettype wire

// File: src/double_to_rational.sv
// ----------------------------------------------------------------------------
// double_to_rational
// Converts the bit pattern of an IEEE-754 double into a sign and an unsigned
// 64-bit numerator over an unsigned 64-bit denominator.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one double per transaction in s_tdata. The master
// channel returns the sign, numerator and denominator in m_tdata. Infinity
// gives 1/0, NaN gives 0/0 and zero gives 0/1; the sign always copies bit 63.
// The block takes one transaction per cycle while s_tready is high. An accepted
// value is held in an input register, converted by trailing and leading zero
// encoders and barrel shifters, and caught in the result register, which drives
// m_tvalid and m_tdata. Throughput is one transaction per cycle while m_tready
// stays high.
// When m_tready is low, the result register holds its transaction and the
// input register keeps one more; s_tready drops only when both are full.
// A low aresetn at a clock edge empties both stages; no result is pending
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module double_to_rational (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // float_bits [63:0]
    input  wire d2r_pkg::in_tdata_t  s_tdata,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // negative [0], numerator [64:1], denominator [128:65], zero fill [135:129]
    output d2r_pkg::out_tdata_t    m_tdata
);

    import d2r_pkg::*;

    logic                    in_valid_reg;
    logic [WORD_BITS-1:0]    bits_reg;
    logic                    out_valid_reg;
    out_tdata_t              out_data_reg;

    logic                    stall;
    logic                    advance;

    logic                    sign;
    logic [EXP_BITS-1:0]     ex;
    logic [FRAC_BITS-1:0]    frac;
    logic [FRAC_BITS:0]      mant;
    logic [5:0]              tz;
    logic [5:0]              msb;
    logic [5:0]              den_exp;
    logic [5:0]              num_msb;
    logic [WORD_BITS-1:0]    num_red;
    logic signed [12:0]      exp_val;
    logic [10:0]             exp_pos;
    logic [10:0]             exp_neg;
    logic [10:0]             k_pos;
    logic [10:0]             e_left;
    logic [6:0]              head;
    logic [10:0]             room;
    logic [10:0]             k_neg;
    logic [10:0]             r_shift;
    logic [5:0]              den_exp_out;
    logic [WORD_BITS-1:0]    num_out;
    logic [WORD_BITS-1:0]    den_out;
    out_tdata_t              out_data_next;

    assign stall    = out_valid_reg && !m_tready;
    assign advance  = !stall;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            bits_reg <= s_tdata;
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign sign = bits_reg[WORD_BITS-1];
    assign ex   = bits_reg[FRAC_BITS +: EXP_BITS];
    assign frac = bits_reg[FRAC_BITS-1:0];
    assign mant = {(ex != '0), frac};

    always_comb begin
        tz = 6'(FRAC_BITS);
        for (int i = FRAC_BITS; i >= 0; i--) begin
            if (mant[i]) begin
                tz = 6'(i);
            end
        end
    end

    always_comb begin
        msb = '0;
        for (int i = 0; i <= FRAC_BITS; i++) begin
            if (mant[i]) begin
                msb = 6'(i);
            end
        end
    end

    assign den_exp = 6'(FRAC_BITS) - tz;
    assign num_msb = msb - tz;
    assign num_red = WORD_BITS'(mant) >> tz;

    assign exp_val = (ex == '0) ? (13'sd1 - EXP_BIAS) : ($signed({2'b00, ex}) - EXP_BIAS);
    assign exp_pos = exp_val[10:0];
    assign exp_neg = 11'(-exp_val);

    assign k_pos   = (exp_pos < 11'(den_exp)) ? exp_pos : 11'(den_exp);
    assign e_left  = exp_pos - k_pos;
    assign head    = 7'd63 - 7'(num_msb);

    assign room    = 11'd63 - 11'(den_exp);
    assign k_neg   = (exp_neg < room) ? exp_neg : room;
    assign r_shift = exp_neg - k_neg;

    always_comb begin
        num_out     = num_red;
        den_exp_out = den_exp;
        den_out     = '0;
        priority if (ex == EXP_MAX) begin
            num_out = (frac == '0) ? 64'd1 : 64'd0;
            den_out = '0;
        end else if (ex == '0 && frac == '0) begin
            num_out = '0;
            den_out = 64'd1;
        end else if (exp_val > 13'sd0) begin
            den_exp_out = den_exp - k_pos[5:0];
            if (e_left > 11'(head)) begin
                num_out = 64'd1;
                den_out = '0;
            end else begin
                num_out = num_red << e_left[5:0];
                den_out = 64'd1 << den_exp_out;
            end
        end else if (exp_val < 13'sd0) begin
            den_exp_out = den_exp + k_neg[5:0];
            num_out     = (r_shift >= 11'd64) ? 64'd0 : (num_red >> r_shift[5:0]);
            den_out     = 64'd1 << den_exp_out;
        end else begin
            den_out = 64'd1 << den_exp;
        end
    end

    assign out_data_next = {7'b0, den_out, num_out, sign};

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: src/d2r_checker.sv
// ----------------------------------------------------------------------------
// d2r_checker
// Port-level checks on the double to rational converter, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_to_rational_assert.svh"

module d2r_checker (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_tready,
    input wire                      m_tvalid,
    input wire                      m_tready,
    input wire d2r_pkg::out_tdata_t m_tdata
);

    import d2r_pkg::*;

    logic [WORD_BITS-1:0] num_w;
    logic [WORD_BITS-1:0] den_w;

    assign num_w   = m_tdata[NUM_MSB:NUM_LSB];
    assign den_w   = m_tdata[DEN_MSB:DEN_LSB];

    `D2R_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result pending after reset")
    `D2R_ASSERT(a_hold_stall, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `D2R_ASSERT(a_busy_stall, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready, "input blocked without a stalled result")
    `D2R_ASSERT(a_den_pow2, aclk, aresetn, m_tvalid |-> $countones(den_w) <= 1, "denominator not a power of two")
    `D2R_ASSERT(a_special, aclk, aresetn, m_tvalid && den_w == '0 |-> num_w[WORD_BITS-1:1] == '0, "infinite or NaN result with wide numerator")

endmodule

bind double_to_rational d2r_checker u_d2r_checker (.*);

`default_nettype wire
